/* rtl/core/captive_dns_query_responder_macros.svh */
// Assertion macros for the captive DNS query responder checker.
// Include with the bare file name; each macro expands to one labeled assertion.
`ifndef CAPTIVE_DNS_QUERY_RESPONDER_MACROS_SVH
`define CAPTIVE_DNS_QUERY_RESPONDER_MACROS_SVH

// Check a property while out of reset.
`define CDQR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define CDQR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/cdqr_pkg.sv */
// Shared types and constants for the captive DNS query responder.
// No dependencies; the design modules refer to it by scoped names.
package cdqr_pkg;

  localparam int MAX_QUERY = 512;
  localparam logic [10:0] MAX_QUERY_W = 11'(MAX_QUERY);

  localparam logic [9:0]  HDR_LEN     = 10'd12;
  localparam logic [10:0] MIN_LEN     = 11'd13;
  localparam logic [7:0]  LABEL_LIMIT = 8'd63;
  localparam logic [9:0]  OFF_LIMIT   = 10'd1023;
  localparam logic [9:0]  QTAIL_LEN   = 10'd5;

  // header byte offsets
  localparam logic [9:0] OFF_FLAGS_HI   = 10'd2;
  localparam logic [9:0] OFF_FLAGS_LO   = 10'd3;
  localparam logic [9:0] OFF_QDCOUNT_HI = 10'd4;
  localparam logic [9:0] OFF_QDCOUNT_LO = 10'd5;
  localparam logic [9:0] OFF_ANCOUNT_HI = 10'd6;
  localparam logic [9:0] OFF_ANCOUNT_LO = 10'd7;

  localparam logic [7:0] FLAG_QR     = 8'h80;
  localparam logic [7:0] FLAG_AA     = 8'h04;
  localparam logic [7:0] FLAG_RA     = 8'h80;
  localparam logic [7:0] OPCODE_MASK = 8'h78;
  localparam logic [7:0] ONE_BYTE    = 8'h01;

  localparam logic [31:0] TYPE_CLASS_A_IN = 32'h0001_0001;
  localparam logic [7:0]  NAME_PTR_HI     = 8'hC0;
  localparam logic [7:0]  RDLEN_A         = 8'h04;
  localparam logic [9:0]  ANSWER_LEN      = 10'd16;

  // register map, indexed by paddr[2]
  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_ANSWER_TTL     = 1'b1;
  localparam logic [31:0] DEVICE_ADDRESS_RESET = 32'd0;
  localparam logic [15:0] ANSWER_TTL_RESET     = 16'd10;

  // result positions within the run caused by one input beat
  localparam logic [4:0] POS_WRITE    = 5'd0;
  localparam logic [4:0] POS_COUNT    = 5'd1;
  localparam logic [4:0] POS_REC0     = 5'd2;
  localparam logic [4:0] POS_REC_LAST = 5'd17;
  localparam logic [4:0] POS_VERDICT  = 5'd18;
  localparam logic [4:0] POS_NONE     = 5'd31;

  typedef struct packed {
    logic [31:0] device_address;
    logic [15:0] answer_ttl;
  } cdqr_cfg_t;

  // everything the emitter needs to replay one input beat's results
  typedef struct packed {
    logic       wr_en;
    logic [9:0] wr_off;
    logic [7:0] wr_val;
    logic       last;
    logic       ok;
    logic       ans;
    logic [9:0] q;
  } cdqr_desc_t;

endpackage

/* rtl/core/cdqr_cfg_regs.sv */
// APB-style configuration registers: device address and answer TTL.
// Depends on cdqr_pkg.
module cdqr_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output cdqr_pkg::cdqr_cfg_t cfg
);

  logic [31:0] device_address_r;
  logic [15:0] answer_ttl_r;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= cdqr_pkg::DEVICE_ADDRESS_RESET;
      answer_ttl_r     <= cdqr_pkg::ANSWER_TTL_RESET;
    end else if (wr_en) begin
      if (cfg_paddr[2] == cdqr_pkg::REG_DEVICE_ADDRESS) begin
        device_address_r <= cfg_pwdata;
      end else begin
        answer_ttl_r <= cfg_pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == cdqr_pkg::REG_ANSWER_TTL) begin
      cfg_prdata = {16'd0, answer_ttl_r};
    end else begin
      cfg_prdata = device_address_r;
    end
  end

  assign cfg.device_address = device_address_r;
  assign cfg.answer_ttl     = answer_ttl_r;

endmodule

/* rtl/core/cdqr_parser.sv */
// Per-datagram parse state: header checks, question label walk, type/class.
// Depends on cdqr_pkg; produces one result descriptor per accepted beat.
module cdqr_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  output cdqr_pkg::cdqr_desc_t desc
);

  logic [9:0]  byte_count_r, byte_count_nxt;
  logic [9:0]  next_label_at_r, next_label_at_nxt;
  logic        root_seen_r, root_seen_nxt;
  logic [9:0]  question_stop_r, question_stop_nxt;
  logic [31:0] type_and_class_r, type_and_class_nxt;
  logic        reject_r, reject_nxt;

  logic [9:0]  p;
  logic        rej;
  logic        emit;
  logic [7:0]  val;
  logic [9:0]  nla;
  logic        root;
  logic [9:0]  qs;
  logic [31:0] tac;
  logic [10:0] nx;
  logic [10:0] len;
  logic        ok;

  always_comb begin
    p    = byte_count_r;
    rej  = reject_r | ({1'b0, p} >= cdqr_pkg::MAX_QUERY_W);
    emit = 1'b0;
    val  = in_byte;
    nla  = next_label_at_r;
    root = root_seen_r;
    qs   = question_stop_r;
    tac  = type_and_class_r;
    nx   = {1'b0, p} + {3'b0, in_byte} + 11'd1;

    if (!rej) begin
      if (p < cdqr_pkg::HDR_LEN) begin
        emit = 1'b1;
        case (p)
          cdqr_pkg::OFF_FLAGS_HI: begin
            if (in_byte[7] || ((in_byte & cdqr_pkg::OPCODE_MASK) != 8'd0)) begin
              rej = 1'b1;
            end
            val = cdqr_pkg::FLAG_QR | cdqr_pkg::FLAG_AA | {7'd0, in_byte[0]};
          end
          cdqr_pkg::OFF_FLAGS_LO: val = cdqr_pkg::FLAG_RA;
          cdqr_pkg::OFF_QDCOUNT_HI: begin
            if (in_byte != 8'd0) rej = 1'b1;
          end
          cdqr_pkg::OFF_QDCOUNT_LO: begin
            if (in_byte != cdqr_pkg::ONE_BYTE) rej = 1'b1;
          end
          // answer count goes out with the final burst
          cdqr_pkg::OFF_ANCOUNT_LO: emit = 1'b0;
          default: begin
            if (p >= cdqr_pkg::OFF_ANCOUNT_HI) val = 8'd0;
          end
        endcase
      end else if (!root) begin
        emit = 1'b1;
        if (p == nla) begin
          if (in_byte == 8'd0) begin
            root = 1'b1;
            qs   = p + cdqr_pkg::QTAIL_LEN;
          end else if (in_byte > cdqr_pkg::LABEL_LIMIT) begin
            rej = 1'b1;
          end else begin
            nla = (nx > {1'b0, cdqr_pkg::OFF_LIMIT}) ? cdqr_pkg::OFF_LIMIT : nx[9:0];
          end
        end
      end else if (p < qs) begin
        emit = 1'b1;
        tac  = {tac[23:0], in_byte};
      end
      if (rej) emit = 1'b0;
    end

    len = {1'b0, p} + 11'd1;
    ok  = !rej && (len >= cdqr_pkg::MIN_LEN) && (len <= cdqr_pkg::MAX_QUERY_W) &&
          root && ({1'b0, qs} <= len);

    desc.wr_en  = emit;
    desc.wr_off = p;
    desc.wr_val = val;
    desc.last   = in_last;
    desc.ok     = in_last & ok;
    desc.ans    = (tac == cdqr_pkg::TYPE_CLASS_A_IN);
    desc.q      = qs;

    // start over after the final beat
    if (in_last) begin
      byte_count_nxt     = 10'd0;
      next_label_at_nxt  = cdqr_pkg::HDR_LEN;
      root_seen_nxt      = 1'b0;
      question_stop_nxt  = 10'd0;
      type_and_class_nxt = 32'd0;
      reject_nxt         = 1'b0;
    end else begin
      byte_count_nxt     = (p < cdqr_pkg::OFF_LIMIT) ? p + 10'd1 : p;
      next_label_at_nxt  = nla;
      root_seen_nxt      = root;
      question_stop_nxt  = qs;
      type_and_class_nxt = tac;
      reject_nxt         = rej;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r     <= 10'd0;
      next_label_at_r  <= cdqr_pkg::HDR_LEN;
      root_seen_r      <= 1'b0;
      question_stop_r  <= 10'd0;
      type_and_class_r <= 32'd0;
      reject_r         <= 1'b0;
    end else if (in_fire) begin
      byte_count_r     <= byte_count_nxt;
      next_label_at_r  <= next_label_at_nxt;
      root_seen_r      <= root_seen_nxt;
      question_stop_r  <= question_stop_nxt;
      type_and_class_r <= type_and_class_nxt;
      reject_r         <= reject_nxt;
    end
  end

endmodule

/* rtl/core/cdqr_emitter.sv */
// Result register and sequencer: replays one descriptor as a run of beats.
// Depends on cdqr_pkg; config values come from cdqr_cfg_regs.
module cdqr_emitter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cdqr_pkg::cdqr_cfg_t  cfg,
  input  cdqr_pkg::cdqr_desc_t desc,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,
  output logic                 out_tlast,
  output logic                 out_tuser
);

  cdqr_pkg::cdqr_desc_t desc_r;
  logic [4:0] pos_r, pos_nxt;
  logic       busy_r, busy_nxt;
  logic [4:0] start_pos;
  logic [4:0] next_pos;
  logic       in_fire;
  logic       out_fire;
  logic [3:0] rec_idx;
  logic [7:0] rec_byte;
  logic [9:0] offset;
  logic [7:0] value;
  logic       send;
  logic [9:0] length;

  always_comb begin
    if (desc.wr_en) begin
      start_pos = cdqr_pkg::POS_WRITE;
    end else if (desc.ok) begin
      start_pos = cdqr_pkg::POS_COUNT;
    end else if (desc.last) begin
      start_pos = cdqr_pkg::POS_VERDICT;
    end else begin
      start_pos = cdqr_pkg::POS_NONE;
    end
  end

  always_comb begin
    case (pos_r)
      cdqr_pkg::POS_WRITE: begin
        if (desc_r.ok) next_pos = cdqr_pkg::POS_COUNT;
        else if (desc_r.last) next_pos = cdqr_pkg::POS_VERDICT;
        else next_pos = cdqr_pkg::POS_NONE;
      end
      cdqr_pkg::POS_COUNT:
        next_pos = desc_r.ans ? cdqr_pkg::POS_REC0 : cdqr_pkg::POS_VERDICT;
      cdqr_pkg::POS_REC_LAST: next_pos = cdqr_pkg::POS_VERDICT;
      cdqr_pkg::POS_VERDICT:  next_pos = cdqr_pkg::POS_NONE;
      cdqr_pkg::POS_NONE:     next_pos = cdqr_pkg::POS_NONE;
      default:                next_pos = pos_r + 5'd1;
    endcase
  end

  // take a new beat when empty or when the run's final beat leaves now
  assign in_tready = !busy_r || (out_tready && (next_pos == cdqr_pkg::POS_NONE));
  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = busy_r & out_tready;

  always_comb begin
    pos_nxt  = pos_r;
    busy_nxt = busy_r;
    if (in_fire) begin
      pos_nxt  = start_pos;
      busy_nxt = (start_pos != cdqr_pkg::POS_NONE);
    end else if (out_fire) begin
      pos_nxt  = next_pos;
      busy_nxt = (next_pos != cdqr_pkg::POS_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= cdqr_pkg::POS_NONE;
      busy_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) desc_r <= desc;
  end

  assign rec_idx = 4'(pos_r - cdqr_pkg::POS_REC0);

  // 16-byte A record: pointer to the question name, A, IN, TTL, rdlength, address
  always_comb begin
    case (rec_idx)
      4'd0:    rec_byte = cdqr_pkg::NAME_PTR_HI;
      4'd1:    rec_byte = cdqr_pkg::HDR_LEN[7:0];
      4'd3:    rec_byte = cdqr_pkg::ONE_BYTE;
      4'd5:    rec_byte = cdqr_pkg::ONE_BYTE;
      4'd8:    rec_byte = cfg.answer_ttl[15:8];
      4'd9:    rec_byte = cfg.answer_ttl[7:0];
      4'd11:   rec_byte = cdqr_pkg::RDLEN_A;
      4'd12:   rec_byte = cfg.device_address[31:24];
      4'd13:   rec_byte = cfg.device_address[23:16];
      4'd14:   rec_byte = cfg.device_address[15:8];
      4'd15:   rec_byte = cfg.device_address[7:0];
      default: rec_byte = 8'd0;
    endcase
  end

  always_comb begin
    offset = 10'd0;
    value  = 8'd0;
    send   = 1'b0;
    length = 10'd0;
    case (pos_r)
      cdqr_pkg::POS_WRITE: begin
        offset = desc_r.wr_off;
        value  = desc_r.wr_val;
      end
      cdqr_pkg::POS_COUNT: begin
        offset = cdqr_pkg::OFF_ANCOUNT_LO;
        value  = {7'd0, desc_r.ans};
      end
      cdqr_pkg::POS_VERDICT: begin
        send = desc_r.ok;
        if (desc_r.ok) begin
          length = desc_r.ans ? desc_r.q + cdqr_pkg::ANSWER_LEN : desc_r.q;
        end
      end
      cdqr_pkg::POS_NONE: begin
        offset = 10'd0;
      end
      default: begin
        offset = desc_r.q + {6'd0, rec_idx};
        value  = rec_byte;
      end
    endcase
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = {3'd0, length, send, value, offset};
  assign out_tlast  = (next_pos == cdqr_pkg::POS_NONE);
  assign out_tuser  = (pos_r == cdqr_pkg::POS_VERDICT);

endmodule

/* rtl/core/captive_dns_query_responder.sv */
// Captive DNS query responder: one datagram byte in per beat, buffer writes out.
// Usage:
//   in_*  : one query byte per beat in in_tdata[7:0]; in_tlast marks the final
//           byte of the datagram.
//   out_* : in_tuser-free results; out_tuser is 0 for a buffer write and 1 for
//           the verdict; out_tlast marks the last beat caused by one input byte.
//   cfg_* : APB-style; 0x0 device address, 0x4 answer TTL (low 16 bits).
// Latency: a result appears the cycle after its input byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one beat and out_tready is high.
//   The final byte yields up to 19 beats (own write, answer count, 16 answer
//   bytes, verdict), sent one per cycle by the result sequencer while out_tready
//   is high; no new byte is taken until the last of them leaves.
// Stall: while out_tready is low the current beat holds and in_tready stays
//   low for as long as a result is waiting.
// Reset: synchronous, active low; clears the parse state, idles the result
//   sequencer (the result register is not reset), sets the address to 0 and the TTL to 10.
// Depends on cdqr_pkg, cdqr_cfg_regs, cdqr_parser, cdqr_emitter.
module captive_dns_query_responder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [9:0] offset, [17:10] value, [18] send, [28:19] length
  output logic        out_tlast,  // run_end
  output logic        out_tuser,  // [0] kind
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cdqr_pkg::cdqr_cfg_t  cfg;
  cdqr_pkg::cdqr_desc_t desc;
  logic                 in_fire;

  assign in_fire = in_tvalid & in_tready;

  cdqr_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  cdqr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .desc    (desc)
  );

  cdqr_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .desc       (desc),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

/* rtl/core/cdqr_checker.sv */
// Port-level checks on the responder's result channel, bound to the top level.
// Depends on captive_dns_query_responder_macros.svh.
`include "captive_dns_query_responder_macros.svh"

module cdqr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  `CDQR_ASSERT_RST(a_reset_idle, !rst_n |=> !out_tvalid, "result valid after reset")
  `CDQR_ASSERT(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled beat changed")
  `CDQR_ASSERT(a_verdict_ends, out_tvalid && out_tuser |-> out_tlast, "verdict not last of run")
  `CDQR_ASSERT(a_drop_len, out_tvalid && out_tuser && !out_tdata[18] |-> out_tdata[28:0] == 29'd0, "drop verdict carries data")
  `CDQR_ASSERT(a_write_clean, out_tvalid && !out_tuser |-> out_tdata[28:18] == 11'd0, "write beat carries verdict fields")

endmodule

bind captive_dns_query_responder cdqr_checker u_cdqr_checker (.*);
